/* rtl/core/iacf_pkg.sv */
// ----------------------------------------------------------------------------
// iacf_pkg
// Types, constants and small tables shared by the attitude filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iacf_pkg;

  // input beat: raw six-axis sample and timestamp
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic        [31:0] time_ms;
  } iacf_in_t;

  // output beat: angles in signed fixed point degrees
  typedef struct packed {
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw;
  } iacf_out_t;

  // configuration write beat
  typedef struct packed {
    logic [2:0]  reg_idx;
    logic [47:0] wdata;
  } iacf_cfg_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_GYRO_RANGE  = 3'd1,
    REG_ACCEL_RANGE = 3'd2,
    REG_LPF_ALPHA   = 3'd3,
    REG_BLEND_ALPHA = 3'd4,
    REG_GYRO_OFFS   = 3'd5,
    REG_ACCEL_OFFS  = 3'd6
  } iacf_reg_e;

  typedef enum logic [1:0] {
    MODE_ACCEL = 2'd0,
    MODE_LPF   = 2'd1,
    MODE_GYRO  = 2'd2,
    MODE_COMP  = 2'd3
  } iacf_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_INIT,
    ST_SQRT,
    ST_CINIT,
    ST_CORD,
    ST_DIVW,
    ST_ROUND,
    ST_BMUL,
    ST_BSUM
  } iacf_state_e;

  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DEN_W      = 17;
  localparam int unsigned PROD_W     = 47;
  localparam int unsigned XY_W       = 35;
  localparam int unsigned Z_W        = 33;
  localparam int unsigned Q24_FRAC   = 24;
  localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000;

  localparam logic [15:0] LPF_ALPHA_RST   = 16'd62259;
  localparam logic [15:0] BLEND_ALPHA_RST = 16'd64881;

  // controller to datapath commands
  typedef struct packed {
    logic             load_in;
    logic             prep;
    logic             mul;
    logic             init;
    logic             sqrt_step;
    logic             div_step;
    logic             cord_init;
    logic             cord_step;
    logic             round;
    logic             bmul;
    logic             commit;
    logic [CNT_W-1:0] step;
  } iacf_cmd_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [29:0] atan_q24(input logic [CNT_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // the gyro sensitivity times one thousand (ms to s)
  function automatic logic [DEN_W-1:0] gyro_den(input logic [1:0] range);
    logic [DEN_W-1:0] v;
    unique case (range)
      2'd0: v = 17'd131000;
      2'd1: v = 17'd65500;
      2'd2: v = 17'd32800;
      2'd3: v = 17'd16400;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/iacf_chan_if.sv */
// ----------------------------------------------------------------------------
// iacf_chan_if
// Valid/ready channel carrying one payload of type T per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface iacf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/imu_attitude_complementary_filter.sv */
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter
// Roll, pitch and yaw from raw six-axis samples in one of four filter modes.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  beat
//  in_i      in   accel x/y/z, gyro x/y/z, time_ms          one raw sample
//  cfg_i     in   reg_idx, wdata                            one register write
//  out_o     out  roll, pitch, yaw                          one angle set
//
//  The three gyro dividers, one quotient bit per cycle, run beside the
//  32-step root units and the CORDIC lanes.
//  One item is in work at a time; the next is taken while a result waits.
//  Reset restores register defaults and zeroes the angle state and the timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_attitude_complementary_filter #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  iacf_chan_if.sink    in_i,
  iacf_chan_if.sink    cfg_i,
  iacf_chan_if.source  out_o
);
  import iacf_pkg::*;

  iacf_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;
  iacf_out_t out_data;

  iacf_ctrl #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  iacf_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_i.data),
    .cfg_we_i  (cfg_i.valid),
    .cfg_data_i(cfg_i.data),
    .out_data_o(out_data)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  // a result is only committed into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid || out_o.ready))
    else $error("commit over an untaken result");

  // a committed result is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("committed result not presented");

  // no new sample is taken while one is still being finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |-> !(cmd.commit || cmd.div_step || cmd.round))
    else $error("sample accepted while busy");

  // rounding only after the dividers have stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> $past(!cmd.div_step))
    else $error("rounding with divider still running");

endmodule

`default_nettype wire

/* rtl/core/iacf_ctrl.sv */
// ----------------------------------------------------------------------------
// iacf_ctrl
// Sequencer: steps one sample through prepare, root, CORDIC, divide and blend.
// ----------------------------------------------------------------------------
`default_nettype none

module iacf_ctrl #(
  parameter int unsigned CORDIC_STEPS    = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output iacf_pkg::iacf_cmd_t cmd_o
);
  import iacf_pkg::*;

  localparam int unsigned DIV_STEPS = PROD_W + 1 + ANGLE_FRAC_BITS;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);

  iacf_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              out_valid_q, out_valid_d;
  logic              div_busy;
  logic              out_free;

  assign div_busy = (dcnt_q != DCNT_W'(DIV_STEPS));
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_INIT;
      ST_INIT:  state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CORD;
      ST_CORD:  if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = ST_DIVW;
      ST_DIVW:  if (!div_busy) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_BMUL;
      ST_BMUL:  state_d = ST_BSUM;
      ST_BSUM:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // commands and counters
  always_comb begin
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_ready_o = 1'b0;
    cnt_d      = '0;
    dcnt_d     = dcnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_MUL:   cmd_o.mul  = 1'b1;
      ST_INIT: begin
        cmd_o.init = 1'b1;
        dcnt_d     = '0;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.div_step  = div_busy;
        cnt_d           = cnt_q + CNT_W'(1);
      end
      ST_CINIT: begin
        cmd_o.cord_init = 1'b1;
        cmd_o.div_step  = div_busy;
      end
      ST_CORD: begin
        cmd_o.cord_step = 1'b1;
        cmd_o.div_step  = div_busy;
        cnt_d           = cnt_q + CNT_W'(1);
      end
      ST_DIVW:  cmd_o.div_step = div_busy;
      ST_ROUND: cmd_o.round    = 1'b1;
      ST_BMUL:  cmd_o.bmul     = 1'b1;
      ST_BSUM:  cmd_o.commit   = out_free;
      default: ;
    endcase
    if (cmd_o.div_step) dcnt_d = dcnt_q + DCNT_W'(1);
  end

  // output beat held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iacf_dp.sv */
// ----------------------------------------------------------------------------
// iacf_dp
// Datapath: offset correction, two root units, two CORDIC lanes, three
// restoring dividers for gyro increments, blend and angle state.
// ----------------------------------------------------------------------------
`default_nettype none

module iacf_dp #(
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iacf_pkg::iacf_cmd_t cmd_i,
  input  iacf_pkg::iacf_in_t  in_data_i,
  input  logic                cfg_we_i,
  input  iacf_pkg::iacf_cfg_t cfg_data_i,
  output iacf_pkg::iacf_out_t out_data_o
);
  import iacf_pkg::*;

  localparam int unsigned NUM_W  = PROD_W + 1 + ANGLE_FRAC_BITS;
  localparam int unsigned RND_SH = Q24_FRAC - ANGLE_FRAC_BITS;
  localparam logic [Z_W-1:0] RND_HALF = Z_W'(1) << (RND_SH - 1);

  // configuration
  iacf_mode_e  mode_q;
  logic [1:0]  gyro_range_q;
  logic [15:0] lpf_alpha_q, blend_alpha_q;
  logic [47:0] gyro_offs_q, accel_offs_q;

  // angle state
  logic [31:0] roll_q, pitch_q, yaw_q, prev_time_q;

  // sample and prepare
  iacf_in_t          raw_q;
  logic [2:0][15:0]  acc_c, gyr_c;
  logic [2:0][15:0]  acc_q;
  logic [2:0][16:0]  mag_q;
  logic [2:0]        gneg_q;
  logic [31:0]       dt_q;

  // products
  logic signed [31:0] sq_x, sq_y, sq_z;
  logic [2:0][48:0]   gprod;
  logic [1:0][31:0]   sum_q;
  logic [2:0][PROD_W-1:0] prod_q;

  // root units
  logic [1:0][63:0] rem_q, res_q, rem_nx, res_nx, sq_t;
  logic [63:0]      bit_q;

  // dividers
  logic [DEN_W-1:0]       den, den_half;
  logic [2:0][NUM_W-1:0]  num_q;
  logic [2:0][DEN_W:0]    drem_q, drem_nx, dr_sh;
  logic [2:0][31:0]       quo_q;
  logic [2:0]             qbit;

  // CORDIC lanes
  logic signed [XY_W-1:0] x_q [2];
  logic signed [XY_W-1:0] y_q [2];
  logic signed [Z_W-1:0]  z_q [2];
  logic signed [XY_W-1:0] x_nx [2];
  logic signed [XY_W-1:0] y_nx [2];
  logic signed [Z_W-1:0]  z_nx [2];
  logic signed [XY_W-1:0] xs [2];
  logic signed [XY_W-1:0] ys [2];
  logic signed [Z_W-1:0]  z_rnd [2];
  logic [1:0]             zero_q;
  logic [Z_W-1:0]         atan_z;

  // blend
  logic [1:0][31:0]       ang_c, ang_q;
  logic [31:0]            pre_roll_q, pre_pitch_q, yaw_nx_q;
  logic                   sel_lpf;
  logic [15:0]            w_sel;
  logic [16:0]            w_inv;
  logic [1:0][31:0]       a_sel;
  logic signed [48:0]     wa_q [2];
  logic signed [49:0]     wb_q [2];
  logic signed [50:0]     bl_s [2];
  logic [1:0][31:0]       blend_ang;
  logic [31:0]            roll_n, pitch_n, yaw_n;
  logic                   upd_time;
  iacf_out_t              out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_COMP;
      gyro_range_q  <= 2'd0;
      lpf_alpha_q   <= LPF_ALPHA_RST;
      blend_alpha_q <= BLEND_ALPHA_RST;
      gyro_offs_q   <= '0;
      accel_offs_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (iacf_reg_e'(cfg_data_i.reg_idx))
        REG_MODE:        mode_q        <= iacf_mode_e'(cfg_data_i.wdata[1:0]);
        REG_GYRO_RANGE:  gyro_range_q  <= cfg_data_i.wdata[1:0];
        REG_ACCEL_RANGE: ; // accel scale cancels in the tilt ratios
        REG_LPF_ALPHA:   lpf_alpha_q   <= cfg_data_i.wdata[15:0];
        REG_BLEND_ALPHA: blend_alpha_q <= cfg_data_i.wdata[15:0];
        REG_GYRO_OFFS:   gyro_offs_q   <= cfg_data_i.wdata;
        REG_ACCEL_OFFS:  accel_offs_q  <= cfg_data_i.wdata;
        default: ;
      endcase
    end
  end

  // offset correction with 16-bit wrap
  assign acc_c[0] = raw_q.accel_x - accel_offs_q[15:0];
  assign acc_c[1] = raw_q.accel_y - accel_offs_q[31:16];
  assign acc_c[2] = raw_q.accel_z - accel_offs_q[47:32];
  assign gyr_c[0] = raw_q.gyro_x - gyro_offs_q[15:0];
  assign gyr_c[1] = raw_q.gyro_y - gyro_offs_q[31:16];
  assign gyr_c[2] = raw_q.gyro_z - gyro_offs_q[47:32];

  // squares and rate times elapsed time
  assign sq_x = $signed(acc_q[0]) * $signed(acc_q[0]);
  assign sq_y = $signed(acc_q[1]) * $signed(acc_q[1]);
  assign sq_z = $signed(acc_q[2]) * $signed(acc_q[2]);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      gprod[l] = 49'(mag_q[l]) * 49'(dt_q);
    end
  end

  assign den      = gyro_den(gyro_range_q);
  assign den_half = den >> 1;

  // root step: one result bit per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq_t[l] = res_q[l] + bit_q;
      if (rem_q[l] >= sq_t[l]) begin
        rem_nx[l] = rem_q[l] - sq_t[l];
        res_nx[l] = (res_q[l] >> 1) + bit_q;
      end else begin
        rem_nx[l] = rem_q[l];
        res_nx[l] = res_q[l] >> 1;
      end
    end
  end

  // restoring divide step: one quotient bit per lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dr_sh[l] = {drem_q[l][DEN_W-1:0], num_q[l][NUM_W-1]};
      if (dr_sh[l] >= {1'b0, den}) begin
        drem_nx[l] = dr_sh[l] - {1'b0, den};
        qbit[l]    = 1'b1;
      end else begin
        drem_nx[l] = dr_sh[l];
        qbit[l]    = 1'b0;
      end
    end
  end

  // vectoring CORDIC rotation
  assign atan_z = Z_W'(atan_q24(cmd_i.step));

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xs[l] = x_q[l] >>> cmd_i.step;
      ys[l] = y_q[l] >>> cmd_i.step;
      if (!y_q[l][XY_W-1]) begin
        x_nx[l] = x_q[l] + ys[l];
        y_nx[l] = y_q[l] - xs[l];
        z_nx[l] = z_q[l] + $signed(atan_z);
      end else begin
        x_nx[l] = x_q[l] - ys[l];
        y_nx[l] = y_q[l] + xs[l];
        z_nx[l] = z_q[l] - $signed(atan_z);
      end
      z_rnd[l] = (z_q[l] + $signed(RND_HALF)) >>> RND_SH;
      ang_c[l] = zero_q[l] ? 32'd0 : z_rnd[l][31:0];
    end
  end

  // blend operands
  assign sel_lpf  = (mode_q == MODE_LPF);
  assign w_sel    = sel_lpf ? lpf_alpha_q : blend_alpha_q;
  assign w_inv    = 17'h10000 - {1'b0, w_sel};
  assign a_sel[0] = sel_lpf ? roll_q : pre_roll_q;
  assign a_sel[1] = sel_lpf ? pitch_q : pre_pitch_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      bl_s[l]      = wa_q[l] + wb_q[l] + 51'sd32768;
      blend_ang[l] = bl_s[l][47:16];
    end
  end

  // new state per mode
  always_comb begin
    roll_n   = roll_q;
    pitch_n  = pitch_q;
    yaw_n    = yaw_q;
    upd_time = 1'b0;
    unique case (mode_q)
      MODE_ACCEL: begin
        roll_n  = ang_q[0];
        pitch_n = ang_q[1];
      end
      MODE_LPF: begin
        roll_n  = blend_ang[0];
        pitch_n = blend_ang[1];
      end
      MODE_GYRO: begin
        roll_n   = pre_roll_q;
        pitch_n  = pre_pitch_q;
        yaw_n    = yaw_nx_q;
        upd_time = 1'b1;
      end
      MODE_COMP: begin
        roll_n   = blend_ang[0];
        pitch_n  = blend_ang[1];
        yaw_n    = yaw_nx_q;
        upd_time = 1'b1;
      end
    endcase
  end

  // angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      prev_time_q <= '0;
    end else if (cmd_i.commit) begin
      roll_q  <= roll_n;
      pitch_q <= pitch_n;
      yaw_q   <= yaw_n;
      if (upd_time) prev_time_q <= raw_q.time_ms;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) raw_q <= in_data_i;

    if (cmd_i.prep) begin
      for (int l = 0; l < 3; l++) begin
        acc_q[l]  <= acc_c[l];
        gneg_q[l] <= gyr_c[l][15];
        mag_q[l]  <= gyr_c[l][15] ? (17'd0 - {1'b1, gyr_c[l]}) : {1'b0, gyr_c[l]};
      end
      dt_q <= raw_q.time_ms - prev_time_q;
    end

    if (cmd_i.mul) begin
      sum_q[0] <= $unsigned(sq_x) + $unsigned(sq_z);
      sum_q[1] <= $unsigned(sq_y) + $unsigned(sq_z);
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= gprod[l][PROD_W-1:0];
      end
    end

    if (cmd_i.init) begin
      bit_q <= SQRT_TOP;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= {sum_q[l], 32'd0};
        res_q[l] <= '0;
      end
      for (int l = 0; l < 3; l++) begin
        num_q[l]  <= NUM_W'({prod_q[l], {ANGLE_FRAC_BITS{1'b0}}}) + NUM_W'(den_half);
        drem_q[l] <= '0;
        quo_q[l]  <= '0;
      end
    end

    if (cmd_i.sqrt_step) begin
      bit_q <= bit_q >> 2;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= rem_nx[l];
        res_q[l] <= res_nx[l];
      end
    end

    if (cmd_i.div_step) begin
      for (int l = 0; l < 3; l++) begin
        drem_q[l] <= drem_nx[l];
        num_q[l]  <= num_q[l] << 1;
        quo_q[l]  <= {quo_q[l][30:0], qbit[l]};
      end
    end

    // roll lane takes ay over the ax/az root, pitch lane ax over the ay/az root
    if (cmd_i.cord_init) begin
      x_q[0]    <= $signed({3'b000, res_q[0][31:0]});
      x_q[1]    <= $signed({3'b000, res_q[1][31:0]});
      y_q[0]    <= $signed({{3{acc_q[1][15]}}, acc_q[1], 16'd0});
      y_q[1]    <= $signed({{3{acc_q[0][15]}}, acc_q[0], 16'd0});
      z_q[0]    <= '0;
      z_q[1]    <= '0;
      zero_q[0] <= (res_q[0][31:0] == 32'd0) && (acc_q[1] == 16'd0);
      zero_q[1] <= (res_q[1][31:0] == 32'd0) && (acc_q[0] == 16'd0);
    end

    if (cmd_i.cord_step) begin
      for (int l = 0; l < 2; l++) begin
        x_q[l] <= x_nx[l];
        y_q[l] <= y_nx[l];
        z_q[l] <= z_nx[l];
      end
    end

    if (cmd_i.round) begin
      ang_q       <= ang_c;
      pre_roll_q  <= gneg_q[0] ? (roll_q - quo_q[0]) : (roll_q + quo_q[0]);
      pre_pitch_q <= gneg_q[1] ? (pitch_q + quo_q[1]) : (pitch_q - quo_q[1]);
      yaw_nx_q    <= gneg_q[2] ? (yaw_q + quo_q[2]) : (yaw_q - quo_q[2]);
    end

    if (cmd_i.bmul) begin
      for (int l = 0; l < 2; l++) begin
        wa_q[l] <= $signed({1'b0, w_sel}) * $signed(a_sel[l]);
        wb_q[l] <= $signed({1'b0, w_inv}) * $signed(ang_q[l]);
      end
    end

    if (cmd_i.commit) begin
      out_q.roll  <= roll_n;
      out_q.pitch <= pitch_n;
      out_q.yaw   <= yaw_n;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* dv/imu_attitude_complementary_filter_tb.sv */
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_tb
// Drives raw samples and register writes into the attitude filter, predicts
// roll, pitch and yaw for every accepted sample and compares each result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_attitude_complementary_filter_tb;
  import iacf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 200;

  logic clk_i;
  logic rst_ni;

  iacf_chan_if #(.T(iacf_in_t))  in_ch  ();
  iacf_chan_if #(.T(iacf_cfg_t)) cfg_ch ();
  iacf_chan_if #(.T(iacf_out_t)) out_ch ();

  imu_attitude_complementary_filter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // predictor state and register copy
  logic [1:0]  cur_mode;
  logic [1:0]  cur_grange;
  logic [1:0]  cur_arange;
  logic [15:0] cur_lpf;
  logic [15:0] cur_blend;
  logic [47:0] cur_goffs;
  logic [47:0] cur_aoffs;
  logic [31:0] roll_q;
  logic [31:0] pitch_q;
  logic [31:0] yaw_q;
  logic [31:0] last_ms;

  iacf_out_t   angles_q[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          hold_sink;
  int unsigned hold_len;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint asr64(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = n;
    res = 0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  function automatic longint atan_step(input int i);
    longint t[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return t[i];
  endfunction

  // tilt angle atan2(num, sqrt(a^2+b^2)) in Q16.16 degrees
  function automatic longint tilt_angle(input longint num, input longint a,
                                        input longint b);
    logic [63:0] sum;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    sum = a * a + b * b;
    x = longint'(isqrt(sum << 32));
    y = num * 65536;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end
    end
    return asr64(z + (64'sd1 << 7), 8);
  endfunction

  function automatic logic [31:0] rate_step(input longint g, input logic [31:0] dt);
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] p;
    logic [63:0] res;
    logic [31:0] v;
    case (cur_grange)
      2'd0:    den = 131000;
      2'd1:    den = 65500;
      2'd2:    den = 32800;
      default: den = 16400;
    endcase
    mag = (g < 0) ? -g : g;
    p = mag * dt;
    res = ((p / den) << 16) + ((((p % den) << 16) + den / 2) / den);
    v = res[31:0];
    return (g < 0) ? -v : v;
  endfunction

  function automatic logic [31:0] mix(input logic [15:0] w, input logic [31:0] a,
                                      input longint b);
    longint s;
    s = longint'(w) * longint'($signed(a)) + (65536 - longint'(w)) * b + 32768;
    return 32'(asr64(s, 16));
  endfunction

  function automatic longint fix(input logic [15:0] raw, input logic [47:0] offs,
                                 input int lane);
    logic [15:0] d;
    d = raw - offs[16*lane +: 16];
    return longint'($signed(d));
  endfunction

  // update the angle state for one sample and record the expected beat
  task automatic predict_angles(input iacf_in_t s);
    longint ax;
    longint ay;
    longint az;
    longint gx;
    longint gy;
    longint gz;
    longint acc_r;
    longint acc_p;
    logic [31:0] dt;
    iacf_out_t e;
    ax = fix(s.accel_x, cur_aoffs, 0);
    ay = fix(s.accel_y, cur_aoffs, 1);
    az = fix(s.accel_z, cur_aoffs, 2);
    gx = fix(s.gyro_x, cur_goffs, 0);
    gy = fix(s.gyro_y, cur_goffs, 1);
    gz = fix(s.gyro_z, cur_goffs, 2);
    acc_r = tilt_angle(ay, ax, az);
    acc_p = tilt_angle(ax, ay, az);
    dt = s.time_ms - last_ms;
    case (iacf_mode_e'(cur_mode))
      MODE_ACCEL: begin
        roll_q = 32'(acc_r);
        pitch_q = 32'(acc_p);
      end
      MODE_LPF: begin
        roll_q = mix(cur_lpf, roll_q, acc_r);
        pitch_q = mix(cur_lpf, pitch_q, acc_p);
      end
      MODE_GYRO: begin
        roll_q = roll_q + rate_step(gx, dt);
        pitch_q = pitch_q - rate_step(gy, dt);
        yaw_q = yaw_q - rate_step(gz, dt);
        last_ms = s.time_ms;
      end
      default: begin
        roll_q = mix(cur_blend, roll_q + rate_step(gx, dt), acc_r);
        pitch_q = mix(cur_blend, pitch_q - rate_step(gy, dt), acc_p);
        yaw_q = yaw_q - rate_step(gz, dt);
        last_ms = s.time_ms;
      end
    endcase
    e.roll = roll_q;
    e.pitch = pitch_q;
    e.yaw = yaw_q;
    angles_q.push_back(e);
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // send one sample beat; valid is dropped by a gap or by wait_idle
  task automatic send_sample(input iacf_in_t s);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_angles(s);
  endtask

  // register write beat
  task automatic write_reg(input iacf_reg_e idx, input logic [47:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.reg_idx <= idx;
    cfg_ch.data.wdata <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MODE:        cur_mode = val[1:0];
      REG_GYRO_RANGE:  cur_grange = val[1:0];
      REG_ACCEL_RANGE: cur_arange = val[1:0];
      REG_LPF_ALPHA:   cur_lpf = val[15:0];
      REG_BLEND_ALPHA: cur_blend = val[15:0];
      REG_GYRO_OFFS:   cur_goffs = val;
      REG_ACCEL_OFFS:  cur_aoffs = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (angles_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic iacf_in_t rand_sample(input bit natural);
    iacf_in_t s;
    s = {$urandom, $urandom, $urandom, $urandom};
    if (natural) begin
      s.accel_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      s.accel_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      s.accel_z = 16'sd16384 + $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
      s.time_ms = last_ms + $urandom_range(1, 20);
    end
    return s;
  endfunction

  task automatic test_extremes();
    iacf_in_t s;
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    write_reg(REG_MODE, MODE_ACCEL);
    // zero vector and corner values of every field
    s = '0;
    send_sample(s);
    for (int i = 0; i < 5; i++) begin
      s.accel_x = ext[i];
      s.accel_y = ext[(i + 1) % 5];
      s.accel_z = ext[(i + 2) % 5];
      s.gyro_x = ext[i];
      s.gyro_y = ext[(i + 3) % 5];
      s.gyro_z = ext[(i + 4) % 5];
      s.time_ms = (i % 2) ? 32'hffff_ffff : 32'h0;
      send_sample(s);
    end
    wait_idle();
  endtask

  task automatic test_modes();
    iacf_in_t s;
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 48'(m));
      for (int i = 0; i < 4; i++) send_sample(rand_sample(i != 3));
      wait_idle();
    end
    // timestamp wrap in gyro mode, large dt after a stale prev time
    write_reg(REG_MODE, MODE_GYRO);
    s = rand_sample(1'b0);
    s.time_ms = 32'hffff_fff0;
    send_sample(s);
    s.time_ms = 32'h0000_0010;
    s.gyro_x = 16'h7fff;
    send_sample(s);
    wait_idle();
  endtask

  task automatic test_config_sweep(input int unsigned n);
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_MODE, 48'($urandom_range(0, 3)));
      write_reg(REG_GYRO_RANGE, (p < 4) ? 48'(p) : 48'($urandom_range(0, 3)));
      write_reg(REG_ACCEL_RANGE, 48'($urandom_range(0, 3)));
      write_reg(REG_LPF_ALPHA, (p == 0) ? 48'h0 : (p == 1) ? 48'hffff : 48'($urandom));
      write_reg(REG_BLEND_ALPHA, (p == 2) ? 48'h0 : (p == 3) ? 48'hffff : 48'($urandom));
      if (p % 3 == 0) begin
        write_reg(REG_GYRO_OFFS, 48'({$urandom, $urandom}));
        write_reg(REG_ACCEL_OFFS, 48'({$urandom, $urandom}));
      end else begin
        write_reg(REG_GYRO_OFFS, {16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                  16'($urandom_range(0, 40))});
        write_reg(REG_ACCEL_OFFS, 48'h0);
      end
      for (int i = 0; i < n; i++) send_sample(rand_sample($urandom_range(0, 9) < 8));
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, MODE_COMP);
    hold_len = 600;
    hold_sink = 1'b1;
    for (int i = 0; i < 8; i++) send_sample(rand_sample(1'b1));
    wait_idle();
  endtask

  // result sink with random stalls and one long hold
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
      @(posedge clk_i);
    end
  end

  // result check
  always @(posedge clk_i) begin
    iacf_out_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (angles_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_ch.data);
      end else begin
        e = angles_q.pop_front();
        if (out_ch.data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r=%h p=%h y=%h got r=%h p=%h y=%h",
                     e.roll, e.pitch, e.yaw,
                     out_ch.data.roll, out_ch.data.pitch, out_ch.data.yaw);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat while results or a sample are pending
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || (angles_q.size() == 0 && !in_ch.valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    hold_sink = 1'b0;
    hold_len = 0;
    cur_mode = MODE_COMP;
    cur_grange = 0;
    cur_arange = 0;
    cur_lpf = LPF_ALPHA_RST;
    cur_blend = BLEND_ALPHA_RST;
    cur_goffs = '0;
    cur_aoffs = '0;
    roll_q = 0;
    pitch_q = 0;
    yaw_q = 0;
    last_ms = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_modes();
    test_backpressure();
    test_config_sweep(72);
    wait_idle();
    if (mismatches == 0 && angles_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
